// File: design/link_local_address_hash_assert.svh
// Assertion macros for the link-local address hash block.
`ifndef LINK_LOCAL_ADDRESS_HASH_ASSERT_SVH
`define LINK_LOCAL_ADDRESS_HASH_ASSERT_SVH
`ifndef SYNTH
`define LLA_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("link_local_address_hash: property failed");
`define LLA_ASSERT_NEXT(label, trig, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
        else $error("link_local_address_hash: next-cycle property failed");
`else
`define LLA_ASSERT(label, prop)
`define LLA_ASSERT_NEXT(label, trig, cond)
`endif
`endif

// File: design/lla_pkg.sv
// Shared constants, types and the LCG step for the link-local address hash.
`timescale 1ns / 1ps
`default_nettype none

package lla_pkg;

    localparam int HASH_TRIES_DEF   = 5;
    localparam int MAX_HW_BYTES_DEF = 8;

    localparam int WORD_W      = 32;
    localparam int HW_ADDR_W   = 64;
    localparam int HW_LEN_W    = 4;
    localparam int CFG_INDEX_W = 2;

    localparam logic [WORD_W-1:0] LCG_MUL    = 32'd1103515245;
    localparam logic [WORD_W-1:0] LCG_ADD    = 32'd12345;
    localparam logic [WORD_W-1:0] MASK_RESET = 32'hFFFF_0000;
    localparam logic [WORD_W-1:0] BASE_RESET = 32'hA9FE_0000;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_SUBNET_MASK = 2'd0,
        REG_SUBNET_BASE = 2'd1
    } cfg_reg_t;

    // Stage enables from the sequencer to the merging adder tree.
    typedef struct packed {
        logic sum_en;
        logic final_en;
    } merge_ctl_t;

    // One linear congruential step, wrapping at 32 bits.
    function automatic logic [WORD_W-1:0] lcg_step(input logic [WORD_W-1:0] x);
        lcg_step = x * LCG_MUL + LCG_ADD;
    endfunction

endpackage

`default_nettype wire

// File: design/lla_lane.sv
// One byte lane: places a hardware address byte at its rotated byte position.
`timescale 1ns / 1ps
`default_nettype none

module lla_lane
    import lla_pkg::*;
#(
    parameter int LANE_IDX = 0
)
(
    input  wire logic              clk,
    input  wire logic              load,
    input  wire logic [7:0]        lane_byte,
    input  wire logic              lane_en,
    input  wire logic [1:0]        start_lane,
    output logic      [WORD_W-1:0] term
);

    logic [1:0]        pos;
    logic [WORD_W-1:0] term_next;
    logic [WORD_W-1:0] term_reg;

    // Byte i lands at lane (start + i) mod 4.
    assign pos = start_lane + 2'(LANE_IDX);

    always_comb
    begin
        if (lane_en)
        begin
            term_next = WORD_W'(lane_byte) << {pos, 3'b000};
        end
        else
        begin
            term_next = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            term_reg <= term_next;
        end
    end

    assign term = term_reg;

endmodule

`default_nettype wire

// File: design/lla_merge.sv
// Two-stage registered adder tree that folds the lane terms into the hash.
`timescale 1ns / 1ps
`default_nettype none

module lla_merge
    import lla_pkg::*;
#(
    parameter int NUM_LANES = MAX_HW_BYTES_DEF
)
(
    input  wire logic                             clk,
    input  wire merge_ctl_t                       ctl,
    input  wire logic [NUM_LANES-1:0][WORD_W-1:0] terms,
    input  wire logic [WORD_W-1:0]                hash_base,
    output logic      [WORD_W-1:0]                hash_out
);

    localparam int NUM_PAIRS = (NUM_LANES + 1) / 2;

    logic [NUM_PAIRS-1:0][WORD_W-1:0] pair_next;
    logic [NUM_PAIRS-1:0][WORD_W-1:0] pair_reg;
    logic [WORD_W-1:0]                base_reg;
    logic [WORD_W-1:0]                final_next;
    logic [WORD_W-1:0]                final_reg;

    genvar p;
    generate
        for (p = 0; p < NUM_PAIRS; p++)
        begin : g_pair
            if (2 * p + 1 < NUM_LANES)
            begin : g_two
                assign pair_next[p] = terms[2*p] + terms[2*p+1];
            end
            else
            begin : g_one
                assign pair_next[p] = terms[2*p];
            end
        end
    endgenerate

    always_comb
    begin
        final_next = base_reg;
        for (int i = 0; i < NUM_PAIRS; i++)
        begin
            final_next = final_next + pair_reg[i];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.sum_en)
        begin
            pair_reg <= pair_next;
            base_reg <= hash_base;
        end
        if (ctl.final_en)
        begin
            final_reg <= final_next;
        end
    end

    assign hash_out = final_reg;

endmodule

`default_nettype wire

// File: design/link_local_address_hash.sv
// Top level of the link-local IPv4 candidate address generator.
//
// Usage:
//   A request on the in channel (hw_address, hw_length, entropy_seed) yields one
//   result on the out channel (address, used_fallback). The stored seed is
//   loaded from entropy_seed only when it is zero, and it is kept across requests.
//   Each try runs two LCG steps through one 32x32 multiplier, then one lane per
//   hardware address byte places its byte and a two-level adder tree merges them.
//   A try steps through LCG1 and LCG2 (two LCG steps), LANE (lane load), SUM and
//   FINAL (two adder levels) and CHECK. A request runs one to HASH_TRIES tries;
//   the block is ready for the next request once its result is registered.
//   Results sit in an output register, so the block takes and works a new request
//   while a result waits; it holds in the check cycle only when it has a new
//   result and the previous one is still not taken.
//   The cfg channel is always ready; index 0 writes subnet_mask, index 1 writes
//   subnet_base, other indexes are ignored.
//   Reset clears the seed to zero, empties the output register and loads the
//   default mask and base.
`timescale 1ns / 1ps
`default_nettype none

`include "link_local_address_hash_assert.svh"

module link_local_address_hash
    import lla_pkg::*;
#(
    parameter int HASH_TRIES   = HASH_TRIES_DEF,
    parameter int MAX_HW_BYTES = MAX_HW_BYTES_DEF
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    output logic                        in_ready,
    input  wire logic [HW_ADDR_W-1:0]   hw_address,
    input  wire logic [HW_LEN_W-1:0]    hw_length,
    input  wire logic [WORD_W-1:0]      entropy_seed,
    output logic                        out_valid,
    input  wire logic                   out_ready,
    output logic      [WORD_W-1:0]      address,
    output logic                        used_fallback,
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [WORD_W-1:0]      cfg_data
);

    localparam int TRY_W = $clog2(HASH_TRIES + 1);

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_LCG1  = 7'b0000010,
        ST_LCG2  = 7'b0000100,
        ST_LANE  = 7'b0001000,
        ST_SUM   = 7'b0010000,
        ST_FINAL = 7'b0100000,
        ST_CHECK = 7'b1000000
    } state_t;

    state_t                        state_reg, state_next;
    logic [TRY_W-1:0]              tries_reg, tries_next;
    logic [WORD_W-1:0]             seed_reg, seed_next;
    logic [WORD_W-1:0]             mask_reg, mask_next;
    logic [WORD_W-1:0]             base_reg, base_next;
    logic                          out_valid_reg, out_valid_next;
    logic [HW_ADDR_W-1:0]          hw_reg, hw_next;
    logic [HW_LEN_W-1:0]           len_reg, len_next;
    logic [15:0]                   hash_hi_reg, hash_hi_next;
    logic [WORD_W-1:0]             hash_base_reg, hash_base_next;
    logic [WORD_W-1:0]             address_reg, address_next;
    logic                          fallback_reg, fallback_next;

    logic [WORD_W-1:0]             hash_now;
    logic [WORD_W-1:0]             hash_final;
    logic [WORD_W-1:0]             host_mask;
    logic [WORD_W-1:0]             host;
    logic                          host_ok;
    logic                          out_free;
    logic [MAX_HW_BYTES-1:0][WORD_W-1:0] lane_terms;
    merge_ctl_t                    merge_ctl;

    assign hash_now  = {hash_hi_reg, seed_reg[31:16]};
    assign host_mask = ~mask_reg;
    assign host      = hash_final & host_mask;
    assign host_ok   = (host != '0) && (host != host_mask);
    assign out_free  = !out_valid_reg || out_ready;

    assign merge_ctl.sum_en   = (state_reg == ST_SUM);
    assign merge_ctl.final_en = (state_reg == ST_FINAL);

    genvar i;
    generate
        for (i = 0; i < MAX_HW_BYTES; i++)
        begin : g_lane
            lla_lane #(
                .LANE_IDX(i)
            ) u_lane (
                .clk        (clk),
                .load       (state_reg == ST_LANE),
                .lane_byte  (hw_reg[8*i +: 8]),
                .lane_en    (len_reg > HW_LEN_W'(i)),
                .start_lane (hash_now[1:0]),
                .term       (lane_terms[i])
            );
        end
    endgenerate

    lla_merge #(
        .NUM_LANES(MAX_HW_BYTES)
    ) u_merge (
        .clk       (clk),
        .ctl       (merge_ctl),
        .terms     (lane_terms),
        .hash_base (hash_base_reg),
        .hash_out  (hash_final)
    );

    always_comb
    begin
        state_next     = state_reg;
        tries_next     = tries_reg;
        seed_next      = seed_reg;
        mask_next      = mask_reg;
        base_next      = base_reg;
        out_valid_next = out_valid_reg;
        hw_next        = hw_reg;
        len_next       = len_reg;
        hash_hi_next   = hash_hi_reg;
        hash_base_next = hash_base_reg;
        address_next   = address_reg;
        fallback_next  = fallback_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        if (cfg_valid)
        begin
            case (cfg_index)
                REG_SUBNET_MASK: mask_next = cfg_data;
                REG_SUBNET_BASE: base_next = cfg_data;
                default:         mask_next = mask_reg;
            endcase
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    hw_next    = hw_address;
                    len_next   = (hw_length > HW_LEN_W'(MAX_HW_BYTES)) ?
                                 HW_LEN_W'(MAX_HW_BYTES) : hw_length;
                    tries_next = '0;
                    if (seed_reg == '0)
                    begin
                        seed_next = entropy_seed;
                    end
                    state_next = ST_LCG1;
                end
            end
            ST_LCG1:
            begin
                seed_next  = lcg_step(seed_reg);
                state_next = ST_LCG2;
            end
            ST_LCG2:
            begin
                hash_hi_next = seed_reg[31:16];
                seed_next    = lcg_step(seed_reg);
                state_next   = ST_LANE;
            end
            ST_LANE:
            begin
                hash_base_next = hash_now;
                state_next     = ST_SUM;
            end
            ST_SUM:
            begin
                state_next = ST_FINAL;
            end
            ST_FINAL:
            begin
                state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                if (host_ok || (tries_reg == TRY_W'(HASH_TRIES - 1)))
                begin
                    // A new result goes out only once the output register is free.
                    if (out_free)
                    begin
                        out_valid_next = 1'b1;
                        fallback_next  = !host_ok;
                        address_next   = host_ok ? (host | base_reg) :
                                         ((WORD_W'(HASH_TRIES) & host_mask) | base_reg);
                        state_next     = ST_IDLE;
                    end
                end
                else
                begin
                    tries_next = tries_reg + TRY_W'(1);
                    state_next = ST_LCG1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            tries_reg     <= '0;
            seed_reg      <= '0;
            mask_reg      <= MASK_RESET;
            base_reg      <= BASE_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            tries_reg     <= tries_next;
            seed_reg      <= seed_next;
            mask_reg      <= mask_next;
            base_reg      <= base_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hw_reg        <= hw_next;
        len_reg       <= len_next;
        hash_hi_reg   <= hash_hi_next;
        hash_base_reg <= hash_base_next;
        address_reg   <= address_next;
        fallback_reg  <= fallback_next;
    end

    assign in_ready      = (state_reg == ST_IDLE);
    assign cfg_ready     = 1'b1;
    assign out_valid     = out_valid_reg;
    assign address       = address_reg;
    assign used_fallback = fallback_reg;

    `LLA_ASSERT(a_fallback_addr, out_valid && used_fallback |-> address == ((WORD_W'(HASH_TRIES) & ~mask_reg) | base_reg))
    `LLA_ASSERT_NEXT(a_seed_nonzero, in_valid && in_ready && (entropy_seed != '0), seed_reg != '0)
    `LLA_ASSERT(a_try_bound, (state_reg == ST_CHECK) |-> (tries_reg <= TRY_W'(HASH_TRIES - 1)))

endmodule

`default_nettype wire
